[sv/iexu_pkg.sv]
// ----------------------------------------------------------------------------
// iexu_pkg : shared types and constants of the I-type execute unit
// Opcodes, decoded item and result layouts and parameter defaults.
// ----------------------------------------------------------------------------
package iexu_pkg;

  localparam int MEM_ADDR_BITS_DEF = 16;
  localparam int NUM_REGS_DEF      = 32;

  localparam logic [5:0] OPC_BEQ   = 6'd4;
  localparam logic [5:0] OPC_BNE   = 6'd5;
  localparam logic [5:0] OPC_ADDI  = 6'd8;
  localparam logic [5:0] OPC_ADDIU = 6'd9;
  localparam logic [5:0] OPC_SLTI  = 6'd10;
  localparam logic [5:0] OPC_SLTIU = 6'd11;
  localparam logic [5:0] OPC_ANDI  = 6'd12;
  localparam logic [5:0] OPC_ORI   = 6'd13;
  localparam logic [5:0] OPC_XORI  = 6'd14;
  localparam logic [5:0] OPC_LUI   = 6'd15;
  localparam logic [5:0] OPC_LB    = 6'd32;
  localparam logic [5:0] OPC_LH    = 6'd33;
  localparam logic [5:0] OPC_LW    = 6'd35;
  localparam logic [5:0] OPC_LBU   = 6'd36;
  localparam logic [5:0] OPC_LHU   = 6'd37;
  localparam logic [5:0] OPC_SB    = 6'd40;
  localparam logic [5:0] OPC_SH    = 6'd41;
  localparam logic [5:0] OPC_SW    = 6'd43;

  // Access size, stored as byte count minus one.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd3;

  typedef enum logic [3:0] {
    K_ADD, K_SLT, K_SLTU, K_AND, K_OR, K_XOR, K_LUI,
    K_BEQ, K_BNE, K_LOAD, K_STORE, K_BAD
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_OP = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  size_m1;
    logic        lsigned;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic [31:0] pc;
  } dec_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        taken;
    logic        we;
    logic [4:0]  idx;
    logic [31:0] value;
    status_t     status;
  } res_t;

endpackage

[sv/iexu_front.sv]
// ----------------------------------------------------------------------------
// iexu_front : instruction intake and classification
// Decodes the opcode of each accepted beat and holds the decoded items in a
// two-entry queue towards the execution back end.
// ----------------------------------------------------------------------------
module iexu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [5:0]          opcode,
  input  logic [4:0]          source_reg,
  input  logic [4:0]          target_reg,
  input  logic [15:0]         immediate,
  input  logic [31:0]         pc,
  output logic                head_valid,
  output iexu_pkg::dec_t      head,
  input  logic                head_pop
);

  iexu_pkg::dec_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  iexu_pkg::dec_t dec;
  logic           do_push;

  always_comb begin
    dec         = '0;
    dec.rs      = source_reg;
    dec.rt      = target_reg;
    dec.imm     = immediate;
    dec.pc      = pc;
    dec.kind    = iexu_pkg::K_BAD;
    dec.size_m1 = iexu_pkg::SZ_BYTE;
    dec.lsigned = 1'b0;
    case (opcode)
      iexu_pkg::OPC_ADDI, iexu_pkg::OPC_ADDIU: dec.kind = iexu_pkg::K_ADD;
      iexu_pkg::OPC_SLTI:  dec.kind = iexu_pkg::K_SLT;
      iexu_pkg::OPC_SLTIU: dec.kind = iexu_pkg::K_SLTU;
      iexu_pkg::OPC_ANDI:  dec.kind = iexu_pkg::K_AND;
      iexu_pkg::OPC_ORI:   dec.kind = iexu_pkg::K_OR;
      iexu_pkg::OPC_XORI:  dec.kind = iexu_pkg::K_XOR;
      iexu_pkg::OPC_LUI:   dec.kind = iexu_pkg::K_LUI;
      iexu_pkg::OPC_BEQ:   dec.kind = iexu_pkg::K_BEQ;
      iexu_pkg::OPC_BNE:   dec.kind = iexu_pkg::K_BNE;
      iexu_pkg::OPC_LB: begin
        dec.kind = iexu_pkg::K_LOAD; dec.lsigned = 1'b1;
      end
      iexu_pkg::OPC_LH: begin
        dec.kind = iexu_pkg::K_LOAD; dec.lsigned = 1'b1; dec.size_m1 = iexu_pkg::SZ_HALF;
      end
      iexu_pkg::OPC_LW: begin
        dec.kind = iexu_pkg::K_LOAD; dec.size_m1 = iexu_pkg::SZ_WORD;
      end
      iexu_pkg::OPC_LBU:   dec.kind = iexu_pkg::K_LOAD;
      iexu_pkg::OPC_LHU: begin
        dec.kind = iexu_pkg::K_LOAD; dec.size_m1 = iexu_pkg::SZ_HALF;
      end
      iexu_pkg::OPC_SB:    dec.kind = iexu_pkg::K_STORE;
      iexu_pkg::OPC_SH: begin
        dec.kind = iexu_pkg::K_STORE; dec.size_m1 = iexu_pkg::SZ_HALF;
      end
      iexu_pkg::OPC_SW: begin
        dec.kind = iexu_pkg::K_STORE; dec.size_m1 = iexu_pkg::SZ_WORD;
      end
      default: dec.kind = iexu_pkg::K_BAD;
    endcase
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];
  assign do_push    = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (head_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(head_pop);
    end
  end

endmodule

[sv/iexu_outq.sv]
// ----------------------------------------------------------------------------
// iexu_outq : result queue
// Two-entry queue holding finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module iexu_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  iexu_pkg::res_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output iexu_pkg::res_t dout
);

  iexu_pkg::res_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_pop;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign dout   = slot[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

endmodule

[sv/iexu_back.sv]
// ----------------------------------------------------------------------------
// iexu_back : execution back end
// Register read stage with execution, then a memory stage that completes
// loads, writes the register file and hands the result on.
// ----------------------------------------------------------------------------
module iexu_back #(
  parameter int MEM_ADDR_BITS = iexu_pkg::MEM_ADDR_BITS_DEF,
  parameter int NUM_REGS      = iexu_pkg::NUM_REGS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  iexu_pkg::dec_t in_item,
  output logic           in_pop,
  input  logic           res_full,
  output logic           res_push,
  output iexu_pkg::res_t res
);

  localparam int ROWS = 2 ** (MEM_ADDR_BITS - 2);

  logic           adv;
  logic [31:0]    regs [NUM_REGS];
  logic           s1_valid;
  iexu_pkg::dec_t s1;
  logic [31:0]    s1_rd_a;
  logic [31:0]    s1_rd_b;
  logic [31:0]    op_a;
  logic [31:0]    op_b;
  logic [31:0]    simm;
  logic [31:0]    zimm;
  logic [31:0]    addr;
  logic [32:0]    end_addr;
  logic           in_range;
  logic           is_store_ok;
  iexu_pkg::res_t ex;

  logic           s2_valid;
  iexu_pkg::res_t s2;
  logic           s2_load;
  logic           s2_lsigned;
  logic [1:0]     s2_size_m1;
  logic [1:0]     s2_lo;
  logic [3:0][7:0] rdata;
  logic [31:0]    s2_value;
  logic           rf_we;

  assign adv    = !(s2_valid && res_full);
  assign in_pop = adv && in_valid;
  assign rf_we  = adv && s2_valid && s2.we;

  // Register file with write-through on the registered read.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (rf_we) begin
      regs[s2.idx] <= s2_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1      <= in_item;
      s1_rd_a <= (rf_we && s2.idx == in_item.rs) ? s2_value : regs[in_item.rs];
      s1_rd_b <= (rf_we && s2.idx == in_item.rt) ? s2_value : regs[in_item.rt];
    end
  end

  // Bypass from the memory stage, which holds the item just ahead.
  always_comb begin
    op_a = s1_rd_a;
    op_b = s1_rd_b;
    if (s2_valid && s2.we && s2.idx == s1.rs) begin
      op_a = s2_value;
    end
    if (s2_valid && s2.we && s2.idx == s1.rt) begin
      op_b = s2_value;
    end
  end

  assign simm     = {{16{s1.imm[15]}}, s1.imm};
  assign zimm     = {16'h0000, s1.imm};
  assign addr     = op_a + simm;
  assign end_addr = {1'b0, addr} + 33'(s1.size_m1);
  assign in_range = (end_addr[32:MEM_ADDR_BITS] == '0);

  always_comb begin
    ex        = '0;
    ex.status = iexu_pkg::ST_OK;
    case (s1.kind)
      iexu_pkg::K_ADD: begin ex.value = op_a + simm; ex.we = 1'b1; end
      iexu_pkg::K_SLT: begin
        ex.value = {31'd0, $signed(op_a) < $signed(simm)}; ex.we = 1'b1;
      end
      iexu_pkg::K_SLTU: begin ex.value = {31'd0, op_a < simm}; ex.we = 1'b1; end
      iexu_pkg::K_AND:  begin ex.value = op_a & zimm; ex.we = 1'b1; end
      iexu_pkg::K_OR:   begin ex.value = op_a | zimm; ex.we = 1'b1; end
      iexu_pkg::K_XOR:  begin ex.value = op_a ^ zimm; ex.we = 1'b1; end
      iexu_pkg::K_LUI:  begin ex.value = {s1.imm, 16'h0000}; ex.we = 1'b1; end
      iexu_pkg::K_BEQ:  ex.taken = (op_a == op_b);
      iexu_pkg::K_BNE:  ex.taken = (op_a != op_b);
      iexu_pkg::K_LOAD: begin
        if (in_range) ex.we = 1'b1;
        else          ex.status = iexu_pkg::ST_RANGE;
      end
      iexu_pkg::K_STORE: begin
        if (!in_range) ex.status = iexu_pkg::ST_RANGE;
      end
      default: ex.status = iexu_pkg::ST_BAD_OP;
    endcase
    if (s1.rt == 5'd0) begin
      ex.we = 1'b0;
    end
    ex.idx = ex.we ? s1.rt : 5'd0;
    if (!ex.we) begin
      ex.value = '0;
    end
    ex.next_pc = s1.pc + 32'd4 + (ex.taken ? {simm[29:0], 2'b00} : 32'd0);
  end

  assign is_store_ok = adv && s1_valid && s1.kind == iexu_pkg::K_STORE && in_range;

  // Data memory in four byte lanes, lane = byte address bits [1:0].
  for (genvar b = 0; b < 4; b++) begin : g_lane
    logic [7:0]               lane_mem [ROWS];
    logic [1:0]               kb;
    logic [MEM_ADDR_BITS-1:0] baddr;
    logic                     lane_we;

    assign kb      = 2'(b) - addr[1:0];
    assign baddr   = addr[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(kb);
    assign lane_we = is_store_ok && (kb <= s1.size_m1);

    always_ff @(posedge clk) begin
      if (lane_we) begin
        lane_mem[baddr[MEM_ADDR_BITS-1:2]] <= 8'(op_b >> {kb, 3'b000});
      end
      if (adv) begin
        rdata[b] <= lane_mem[baddr[MEM_ADDR_BITS-1:2]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2         <= ex;
      s2_load    <= (s1.kind == iexu_pkg::K_LOAD);
      s2_lsigned <= s1.lsigned;
      s2_size_m1 <= s1.size_m1;
      s2_lo      <= addr[1:0];
    end
  end

  always_comb begin
    logic [31:0] raw;
    raw = '0;
    for (int k = 0; k < 4; k++) begin
      raw[8*k +: 8] = rdata[2'(s2_lo + 2'(k))];
    end
    s2_value = s2.value;
    if (s2_load && s2.we) begin
      case (s2_size_m1)
        iexu_pkg::SZ_BYTE: s2_value = {{24{s2_lsigned & raw[7]}}, raw[7:0]};
        iexu_pkg::SZ_HALF: s2_value = {{16{s2_lsigned & raw[15]}}, raw[15:0]};
        default:           s2_value = raw;
      endcase
    end
  end

  always_comb begin
    res       = s2;
    res.value = s2_value;
  end

  assign res_push = s2_valid && adv;

endmodule

[sv/mips_itype_execute_unit_top.sv]
// ----------------------------------------------------------------------------
// mips_itype_execute_unit_top : MIPS32 I-type execute unit
// Executes one I-type instruction per beat against a register file and a
// byte-addressed little-endian data memory and returns one result per beat.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          beat accepted when
//  -------   ---------  -----------------  -----------------------
//  input     in         push / full        push high, full low
//  result    out        empty / pop        pop high, empty low
//
// While results are popped, one instruction is accepted every cycle and
// results leave at one per cycle. An instruction passes the front queue,
// register read with execute, data memory read with write-back and the
// result queue in that order; the two back-end stages set the rate and
// bypass results so that dependent instructions follow back to back. Reset
// is synchronous and clears the queues, the pipeline valids and the register
// file; data memory is not cleared. A stalled result queue freezes the back
// end; the front queue keeps accepting until its two entries are taken.
//
module mips_itype_execute_unit_top #(
  parameter int MEM_ADDR_BITS = iexu_pkg::MEM_ADDR_BITS_DEF,
  parameter int NUM_REGS      = iexu_pkg::NUM_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [5:0]  opcode,
  input  logic [4:0]  source_reg,
  input  logic [4:0]  target_reg,
  input  logic [15:0] immediate,
  input  logic [31:0] pc,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] next_pc,
  output logic        branch_taken,
  output logic        write_enable,
  output logic [4:0]  write_index,
  output logic [31:0] write_value,
  output logic [1:0]  status
);

  logic           mid_valid;
  iexu_pkg::dec_t mid_item;
  logic           mid_pop;
  logic           res_full;
  logic           res_push;
  iexu_pkg::res_t res_in;
  iexu_pkg::res_t res_out;

  // Front end: decoding and the queue towards the back end.
  iexu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .source_reg (source_reg),
    .target_reg (target_reg),
    .immediate  (immediate),
    .pc         (pc),
    .head_valid (mid_valid),
    .head       (mid_item),
    .head_pop   (mid_pop)
  );

  // Back end: register file, data memory and the two execution stages.
  iexu_back #(
    .MEM_ADDR_BITS (MEM_ADDR_BITS),
    .NUM_REGS      (NUM_REGS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mid_valid),
    .in_item  (mid_item),
    .in_pop   (mid_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // Result queue: decouples the consumer from the back end.
  iexu_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign next_pc      = res_out.next_pc;
  assign branch_taken = res_out.taken;
  assign write_enable = res_out.we;
  assign write_index  = res_out.idx;
  assign write_value  = res_out.value;
  assign status       = res_out.status;

  // A register write never names register zero.
  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    (!empty && write_enable) |-> (write_index != 5'd0))
    else $error("result writes register zero");

  // A flagged result carries neither a write nor a taken branch.
  a_flag_no_effect: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != iexu_pkg::ST_OK) |-> (!write_enable && !branch_taken))
    else $error("flagged result has an effect");

  // The back end never pushes into a full result queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overflow");

  // A result that was not popped stays on the ports.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(write_value) && $stable(next_pc)))
    else $error("waiting result changed");

endmodule
